FILE: sv/sbpf_pkg.sv
package sbpf_pkg;

   localparam int SQRT_CELLS = 34;
   localparam int DIV_CELLS  = 32;

   localparam logic [2:0] REG_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_CENTER_Z    = 3'd2;
   localparam logic [2:0] REG_WALL_RADIUS = 3'd3;
   localparam logic [2:0] REG_INV_STEP_SQ = 3'd4;

   typedef logic [32:0] mag_type;

   typedef struct packed {
      logic              outside;
      logic [2:0]        pos;
      mag_type [2:0]     mag;
   } side_type;

   typedef struct packed {
      logic [67:0] val;
      logic [37:0] rem;
      logic [33:0] root;
      side_type    side;
   } sqrt_type;

   typedef struct packed {
      logic [2:0][41:0] rem;
      logic [2:0][31:0] low;
      logic [2:0][31:0] quo;
      logic [2:0]       ovf;
      logic [2:0]       pos;
      logic             outside;
      logic [41:0]      dvs;
   } div_type;

endpackage

FILE: sv/sbpf_front.sv
module sbpf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [2:0][31:0]       in_pos,
   input  logic [2:0][31:0]       center,
   input  logic [61:0]            r_sq,
   input  logic                   hold_in,
   output logic                   hold_out,
   output logic                   out_valid,
   output sbpf_pkg::sqrt_type     out_data
);
   import sbpf_pkg::*;

   logic                va_ff, vb_ff, vc_ff, vd_ff;
   logic                hold_a, hold_b, hold_c, hold_d;
   logic [2:0][32:0]    diff_ff;
   logic [2:0][65:0]    sq_ff;
   mag_type [2:0]       mag_b_ff, mag_c_ff, mag_in;
   logic [2:0]          pos_b_ff, pos_c_ff, pos_in;
   logic [67:0]         dist2_ff;
   sqrt_type            out_ff;

   assign hold_d   = vd_ff & hold_in;
   assign hold_c   = vc_ff & hold_d;
   assign hold_b   = vb_ff & hold_c;
   assign hold_a   = va_ff & hold_b;
   assign hold_out = hold_a;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = diff_ff[i][32] ? 33'(-diff_ff[i]) : diff_ff[i];
         pos_in[i] = !diff_ff[i][32] && (diff_ff[i] != 33'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (!hold_a) va_ff <= in_valid;
         if (!hold_b) vb_ff <= va_ff;
         if (!hold_c) vc_ff <= vb_ff;
         if (!hold_d) vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_a) begin
         for (int i = 0; i < 3; i++)
            diff_ff[i] <= {in_pos[i][31], in_pos[i]} - {center[i][31], center[i]};
      end
      if (!hold_b) begin
         for (int i = 0; i < 3; i++)
            sq_ff[i] <= 66'(mag_in[i]) * 66'(mag_in[i]);
         mag_b_ff <= mag_in;
         pos_b_ff <= pos_in;
      end
      if (!hold_c) begin
         dist2_ff <= 68'(sq_ff[0]) + 68'(sq_ff[1]) + 68'(sq_ff[2]);
         mag_c_ff <= mag_b_ff;
         pos_c_ff <= pos_b_ff;
      end
      if (!hold_d) begin
         out_ff.val          <= dist2_ff;
         out_ff.rem          <= '0;
         out_ff.root         <= '0;
         out_ff.side.outside <= dist2_ff > 68'(r_sq);
         out_ff.side.pos     <= pos_c_ff;
         out_ff.side.mag     <= mag_c_ff;
      end
   end

   assign out_valid = vd_ff;
   assign out_data  = out_ff;

endmodule

FILE: sv/sbpf_sqrt_cell.sv
module sbpf_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sbpf_pkg::sqrt_type     in_data,
   input  logic                   hold_in,
   output logic                   hold_out,
   output logic                   out_valid,
   output sbpf_pkg::sqrt_type     out_data
);
   import sbpf_pkg::*;

   logic        v_ff;
   sqrt_type    d_ff, d_in;
   logic [37:0] rem_s;
   logic [37:0] trial;
   logic        ge;

   assign hold_out = v_ff & hold_in;

   always_comb begin
      rem_s = {in_data.rem[35:0], in_data.val[67:66]};
      trial = {2'b00, in_data.root, 2'b01};
      ge    = rem_s >= trial;
      d_in      = in_data;
      d_in.val  = {in_data.val[65:0], 2'b00};
      d_in.rem  = ge ? rem_s - trial : rem_s;
      d_in.root = {in_data.root[32:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (!hold_out) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_out) d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

FILE: sv/sbpf_scale.sv
module sbpf_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sbpf_pkg::sqrt_type     in_data,
   input  logic [30:0]            wall_radius,
   input  logic [31:0]            inv_step_sq,
   input  logic                   hold_in,
   output logic                   hold_out,
   output logic                   out_valid,
   output sbpf_pkg::div_type      out_data
);
   import sbpf_pkg::*;

   logic             v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic             h0, h1, h2, h3, h4;
   logic [33:0]      over_ff;
   logic [65:0]      ok_ff;
   logic [41:0]      dvs0_ff, dvs1_ff, dvs2_ff, dvs3_ff;
   side_type         s0_ff, s1_ff;
   logic [2:0]       pos2_ff, pos3_ff;
   logic             out2_ff, out3_ff;
   logic [2:0][81:0] plo_ff;
   logic [2:0][82:0] phi_ff;
   logic [2:0][98:0] n_ff;
   div_type          o_ff;

   assign h4 = v4_ff & hold_in;
   assign h3 = v3_ff & h4;
   assign h2 = v2_ff & h3;
   assign h1 = v1_ff & h2;
   assign h0 = v0_ff & h1;
   assign hold_out = h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (!h0) v0_ff <= in_valid;
         if (!h1) v1_ff <= v0_ff;
         if (!h2) v2_ff <= v1_ff;
         if (!h3) v3_ff <= v2_ff;
         if (!h4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!h0) begin
         over_ff <= (in_data.root > 34'(wall_radius)) ?
                    in_data.root - 34'(wall_radius) : 34'd0;
         dvs0_ff <= {in_data.root, 8'd0};
         s0_ff   <= in_data.side;
      end
      if (!h1) begin
         ok_ff   <= 66'(over_ff) * 66'(inv_step_sq);
         dvs1_ff <= dvs0_ff;
         s1_ff   <= s0_ff;
      end
      if (!h2) begin
         for (int i = 0; i < 3; i++) begin
            plo_ff[i] <= 82'(ok_ff) * 82'(s1_ff.mag[i][15:0]);
            phi_ff[i] <= 83'(ok_ff) * 83'(s1_ff.mag[i][32:16]);
         end
         dvs2_ff <= dvs1_ff;
         pos2_ff <= s1_ff.pos;
         out2_ff <= s1_ff.outside;
      end
      if (!h3) begin
         for (int i = 0; i < 3; i++)
            n_ff[i] <= 99'(plo_ff[i]) + {phi_ff[i], 16'd0};
         dvs3_ff <= dvs2_ff;
         pos3_ff <= pos2_ff;
         out3_ff <= out2_ff;
      end
      if (!h4) begin
         for (int i = 0; i < 3; i++) begin
            o_ff.ovf[i] <= n_ff[i][98:32] >= 67'(dvs3_ff);
            o_ff.rem[i] <= n_ff[i][73:32];
            o_ff.low[i] <= n_ff[i][31:0];
            o_ff.quo[i] <= '0;
         end
         o_ff.dvs     <= dvs3_ff;
         o_ff.pos     <= pos3_ff;
         o_ff.outside <= out3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = o_ff;

endmodule

FILE: sv/sbpf_div_cell.sv
module sbpf_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sbpf_pkg::div_type      in_data,
   input  logic                   hold_in,
   output logic                   hold_out,
   output logic                   out_valid,
   output sbpf_pkg::div_type      out_data
);
   import sbpf_pkg::*;

   logic             v_ff;
   div_type          d_ff, d_in;
   logic [2:0][42:0] rem_s;
   logic [2:0]       ge;

   assign hold_out = v_ff & hold_in;

   always_comb begin
      d_in = in_data;
      for (int i = 0; i < 3; i++) begin
         rem_s[i] = {in_data.rem[i], in_data.low[i][31]};
         ge[i]    = rem_s[i] >= {1'b0, in_data.dvs};
         d_in.rem[i] = ge[i] ? 42'(rem_s[i] - {1'b0, in_data.dvs}) : rem_s[i][41:0];
         d_in.low[i] = {in_data.low[i][30:0], 1'b0};
         d_in.quo[i] = {in_data.quo[i][30:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (!hold_out) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_out) d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

FILE: sv/sphere_boundary_penalty_force.sv
// Pipeline from the acceptance of a req transaction to rsp_tvalid, 76 register stages:
// 4 front, 34 square-root cells, 5 scaling, 32 divider cells and the output register.
// Throughput: one transaction per cycle unless stalled; every cell holds one item and passes it on.
// A stalled output holds only the cells that are full, so bubbles still collapse upstream.
// Reset (synchronous, active high) empties the pipeline and loads center 0, radius 1.0, k 1.0.
module sphere_boundary_penalty_force (
   input  logic         clock,
   input  logic         reset,
   // tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64]
   input  logic [95:0]  req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: force_x [31:0], force_y [63:32], force_z [95:64]
   output logic [95:0]  rsp_tdata,
   // tuser: outside [0], saturated [1]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import sbpf_pkg::*;

   // configuration registers
   logic [2:0][31:0] center_ff;
   logic [30:0]      radius_ff;
   logic [31:0]      k_ff;
   logic [61:0]      r_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         radius_ff <= 31'd65536;
         k_ff      <= 32'd256;
      end else if (csr_wen) begin
         case (csr_index)
            REG_CENTER_X:    center_ff[0] <= csr_wdata;
            REG_CENTER_Y:    center_ff[1] <= csr_wdata;
            REG_CENTER_Z:    center_ff[2] <= csr_wdata;
            REG_WALL_RADIUS: radius_ff    <= csr_wdata[30:0];
            REG_INV_STEP_SQ: k_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   // radius squared is registered; the user must write only when idle, unenforced by the block
   always_ff @(posedge clock) begin
      r_sq_ff <= 62'(radius_ff) * 62'(radius_ff);
   end

   // front end: difference, squares, sum, wall compare
   logic              fr_hold, fr_valid;
   sqrt_type          fr_data;
   logic [2:0][31:0]  in_pos;

   assign in_pos = req_tdata;

   logic [SQRT_CELLS:0] sq_valid, sq_hold;
   sqrt_type            sq_data [SQRT_CELLS+1];

   sbpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_pos    (in_pos),
      .center    (center_ff),
      .r_sq      (r_sq_ff),
      .hold_in   (sq_hold[0]),
      .hold_out  (fr_hold),
      .out_valid (fr_valid),
      .out_data  (fr_data)
   );

   assign req_tready  = !fr_hold;
   assign sq_valid[0] = fr_valid;
   assign sq_data[0]  = fr_data;

   // one root bit per cell, most significant first
   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      sbpf_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[g]),
         .in_data   (sq_data[g]),
         .hold_in   (sq_hold[g+1]),
         .hold_out  (sq_hold[g]),
         .out_valid (sq_valid[g+1]),
         .out_data  (sq_data[g+1])
      );
   end

   // over-distance, gain product, numerators, overflow check
   logic [DIV_CELLS:0] dv_valid, dv_hold;
   div_type            dv_data [DIV_CELLS+1];

   sbpf_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sq_valid[SQRT_CELLS]),
      .in_data     (sq_data[SQRT_CELLS]),
      .wall_radius (radius_ff),
      .inv_step_sq (k_ff),
      .hold_in     (dv_hold[0]),
      .hold_out    (sq_hold[SQRT_CELLS]),
      .out_valid   (dv_valid[0]),
      .out_data    (dv_data[0])
   );

   // restoring division, one quotient bit per cell for all three lanes
   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      sbpf_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[g]),
         .in_data   (dv_data[g]),
         .hold_in   (dv_hold[g+1]),
         .hold_out  (dv_hold[g]),
         .out_valid (dv_valid[g+1]),
         .out_data  (dv_data[g+1])
      );
   end

   // output register: clamp, apply sign opposite to the offset, zero inside the wall
   div_type          fin;
   logic             out_hold;
   logic [2:0]       big;
   logic [2:0][31:0] lim, clamp;
   logic [95:0]      tdata_in;
   logic [1:0]       tuser_in;
   logic             vout_ff;
   logic [95:0]      tdata_ff;
   logic [1:0]       tuser_ff;

   assign fin      = dv_data[DIV_CELLS];
   assign out_hold = vout_ff & !rsp_tready;
   assign dv_hold[DIV_CELLS] = out_hold;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lim[i]   = fin.pos[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         big[i]   = fin.ovf[i] || (fin.quo[i] > lim[i]);
         clamp[i] = big[i] ? lim[i] : fin.quo[i];
         tdata_in[32*i +: 32] = !fin.outside ? 32'd0 :
                                fin.pos[i] ? 32'(-clamp[i]) : clamp[i];
      end
      tuser_in = {fin.outside && (big != 3'd0), fin.outside};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (!out_hold) begin
         vout_ff <= dv_valid[DIV_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (!out_hold) begin
         tdata_ff <= tdata_in;
         tuser_ff <= tuser_in;
      end
   end

   assign rsp_tvalid = vout_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tuser  = tuser_ff;

endmodule

FILE: sv/sbpf_checker.sv
module sbpf_checker (
   input logic        clock,
   input logic        reset,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // hold a stalled transaction
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // inside the wall means zero force and no clamp
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 96'd0 && !rsp_tuser[1])
      else $error("nonzero force for a particle inside the wall");

   // clamping happens only outside
   a_sat_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("saturated set without outside");

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

endmodule

bind sphere_boundary_penalty_force sbpf_checker u_sbpf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
